// ===== hdl/assert_macros.svh =====
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== hdl/iqr_pkg.sv =====
`timescale 1ns / 1ps
package iqr_pkg;
    localparam int IQR_MAX_SAMPLES = 256;
    localparam int IQR_SAMPLE_BITS = 16;
    localparam int ITEM_BITS       = 32;
    localparam int SPREAD_BITS     = 17;
    localparam int SPREAD_MAX      = 131071;
    localparam int FIFO_DEPTH      = 4;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last_sample;
    } t_iqr_in;

    typedef struct packed {
        logic [SPREAD_BITS-1:0] quartile_spread;
        logic                   set_error;
    } t_iqr_out;

    typedef struct packed {
        logic signed [ITEM_BITS-1:0] value;
        logic                        last;
    } t_iqr_item;

    typedef struct packed {
        logic valid;
        logic pop;
    } t_iqr_link;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_INS0,
        ST_CLOSE,
        ST_QRD,
        ST_QACC,
        ST_DONE
    } t_iqr_state;
endpackage

// ===== hdl/iqr_ram.sv =====
`timescale 1ns / 1ps
module iqr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/iqr_front.sv =====
`timescale 1ns / 1ps
module iqr_front #(
    parameter int SAMPLE_BITS = iqr_pkg::IQR_SAMPLE_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  iqr_pkg::t_iqr_in    i_in_data,
    output iqr_pkg::t_iqr_item  o_item,
    input  iqr_pkg::t_iqr_link  i_link,
    output logic                o_valid
);
    localparam int PW = $clog2(iqr_pkg::FIFO_DEPTH);
    localparam int CW = $clog2(iqr_pkg::FIFO_DEPTH + 1);

    iqr_pkg::t_iqr_item r_buf [iqr_pkg::FIFO_DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_cnt;
    logic [iqr_pkg::ITEM_BITS-1:0] w_raw;
    logic signed [SAMPLE_BITS-1:0] w_bits;
    iqr_pkg::t_iqr_item w_item;
    logic w_wr, w_rd;

    // sign extend from the low sample bits
    assign w_raw        = iqr_pkg::ITEM_BITS'(unsigned'(i_in_data.sample));
    assign w_bits       = w_raw[SAMPLE_BITS-1:0];
    assign w_item.value = iqr_pkg::ITEM_BITS'(w_bits);
    assign w_item.last  = i_in_data.last_sample;

    assign o_full  = (r_cnt == CW'(iqr_pkg::FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_buf[r_rptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_link.pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_buf[r_wptr] <= w_item;
        end
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_wr) r_wptr <= r_wptr + PW'(1);
            if (w_rd) r_rptr <= r_rptr + PW'(1);
            r_cnt <= r_cnt + CW'(w_wr) - CW'(w_rd);
        end
    end
endmodule

// ===== hdl/iqr_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module iqr_back #(
    parameter int MAX_SAMPLES = iqr_pkg::IQR_MAX_SAMPLES,
    parameter int SAMPLE_BITS = iqr_pkg::IQR_SAMPLE_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  iqr_pkg::t_iqr_item i_item,
    input  logic               i_valid,
    output iqr_pkg::t_iqr_link o_link,
    output logic               o_empty,
    input  logic               i_pop,
    output iqr_pkg::t_iqr_out  o_out_data
);
    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int DW = SAMPLE_BITS + 3;
    localparam int XW = 40;

    iqr_pkg::t_iqr_state r_state, n_state;
    logic signed [SAMPLE_BITS-1:0] r_val, n_val;
    logic r_last, n_last;
    logic [AW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_count, n_count;
    logic r_ovf, n_ovf;
    logic [1:0] r_step, n_step;
    logic signed [DW-1:0] r_acc, n_acc;
    logic r_err, n_err;
    logic r_out_valid, n_out_valid;
    iqr_pkg::t_iqr_out r_out, n_out;

    logic w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [SAMPLE_BITS-1:0] w_wdata, w_rdata;
    logic signed [SAMPLE_BITS-1:0] w_rs;
    logic [CW-1:0] w_h, w_k, w_idx;
    logic w_odd, w_sub, w_dbl, w_endq;
    logic signed [DW-1:0] w_term;
    logic signed [XW-1:0] w_accx;

    iqr_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_rs  = w_rdata;
    assign w_h   = r_count >> 1;
    assign w_k   = w_h >> 1;
    assign w_odd = w_h[0];

    // quartile read order and weights
    always_comb begin
        w_idx = '0;
        w_sub = 1'b0;
        w_dbl = w_odd;
        case (r_step)
            2'd0: w_idx = r_count - CW'(1) - (w_odd ? w_k : CW'(0)) - (w_odd ? CW'(0) : w_k)
                          + (w_odd ? CW'(0) : CW'(1));
            2'd1: begin
                w_idx = w_odd ? w_k : r_count - CW'(1) - w_k;
                w_sub = w_odd;
            end
            2'd2: begin
                w_idx = w_k;
                w_sub = 1'b1;
            end
            default: begin
                w_idx = w_k - CW'(1);
                w_sub = 1'b1;
            end
        endcase
    end

    assign w_endq = w_odd ? (r_step == 2'd1) : (r_step == 2'd3);
    assign w_term = w_dbl ? (DW'(w_rs) <<< 1) : DW'(w_rs);
    assign w_accx = XW'(r_acc);

    always_comb begin
        n_state     = r_state;
        n_val       = r_val;
        n_last      = r_last;
        n_pos       = r_pos;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_step      = r_step;
        n_acc       = r_acc;
        n_err       = r_err;
        n_out_valid = r_out_valid && !i_pop;
        n_out       = r_out;
        w_we        = 1'b0;
        w_waddr     = r_pos;
        w_wdata     = r_val;
        w_raddr     = r_pos - AW'(2);
        o_link.pop  = 1'b0;
        case (r_state)
            iqr_pkg::ST_IDLE: begin
                w_raddr = AW'(r_count - CW'(1));
                if (i_valid) begin
                    o_link.pop = 1'b1;
                    n_val  = i_item.value[SAMPLE_BITS-1:0];
                    n_last = i_item.last;
                    n_pos  = AW'(r_count);
                    if (r_count == CW'(MAX_SAMPLES)) begin
                        n_ovf   = 1'b1;
                        n_state = iqr_pkg::ST_CLOSE;
                    end else if (r_count == '0) begin
                        n_state = iqr_pkg::ST_INS0;
                    end else begin
                        n_state = iqr_pkg::ST_CMP;
                    end
                end
            end
            iqr_pkg::ST_CMP: begin
                w_we = 1'b1;
                if (w_rs > r_val) begin
                    w_wdata = w_rdata;
                    n_pos   = r_pos - AW'(1);
                    if (r_pos == AW'(1)) n_state = iqr_pkg::ST_INS0;
                end else begin
                    n_count = r_count + CW'(1);
                    n_state = iqr_pkg::ST_CLOSE;
                end
            end
            iqr_pkg::ST_INS0: begin
                w_we    = 1'b1;
                w_waddr = '0;
                n_count = r_count + CW'(1);
                n_state = iqr_pkg::ST_CLOSE;
            end
            iqr_pkg::ST_CLOSE: begin
                n_step = '0;
                n_acc  = '0;
                n_err  = r_ovf || (r_count < CW'(2));
                if (!r_last) begin
                    n_state = iqr_pkg::ST_IDLE;
                end else if (r_ovf || (r_count < CW'(2))) begin
                    n_state = iqr_pkg::ST_DONE;
                end else begin
                    n_state = iqr_pkg::ST_QRD;
                end
            end
            iqr_pkg::ST_QRD: begin
                w_raddr = w_idx[AW-1:0];
                n_state = iqr_pkg::ST_QACC;
            end
            iqr_pkg::ST_QACC: begin
                n_acc = w_sub ? r_acc - w_term : r_acc + w_term;
                if (w_endq) begin
                    n_state = iqr_pkg::ST_DONE;
                end else begin
                    n_step  = r_step + 2'd1;
                    n_state = iqr_pkg::ST_QRD;
                end
            end
            iqr_pkg::ST_DONE: begin
                if (!r_out_valid || i_pop) begin
                    n_out_valid         = 1'b1;
                    n_out.set_error     = r_err;
                    if (r_err || r_acc < 0) begin
                        n_out.quartile_spread = '0;
                    end else if (w_accx > XW'(iqr_pkg::SPREAD_MAX)) begin
                        n_out.quartile_spread = iqr_pkg::SPREAD_BITS'(iqr_pkg::SPREAD_MAX);
                    end else begin
                        n_out.quartile_spread = w_accx[iqr_pkg::SPREAD_BITS-1:0];
                    end
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_state = iqr_pkg::ST_IDLE;
                end
            end
            default: n_state = iqr_pkg::ST_IDLE;
        endcase
    end

    assign o_link.valid = i_valid;
    assign o_empty      = !r_out_valid;
    assign o_out_data   = r_out;

    always_ff @(posedge i_clk) begin
        r_val  <= n_val;
        r_last <= n_last;
        r_pos  <= n_pos;
        r_step <= n_step;
        r_acc  <= n_acc;
        r_err  <= n_err;
        r_out  <= n_out;
        if (!i_rst_n) begin
            r_state     <= iqr_pkg::ST_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    `ASSERT_NEVER(a_count_cap, i_clk, i_rst_n, r_count > CW'(MAX_SAMPLES))
    `ASSERT_CLK(a_load_from_done, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state) == iqr_pkg::ST_DONE)
    `ASSERT_CLK(a_err_zero, i_clk, i_rst_n, (r_out_valid && r_out.set_error) |-> r_out.quartile_spread == '0)
    `ASSERT_NEVER(a_write_in_quartile, i_clk, i_rst_n, w_we && (r_state == iqr_pkg::ST_QRD || r_state == iqr_pkg::ST_QACC))
endmodule

// ===== hdl/interquartile_range_core.sv =====
`timescale 1ns / 1ps
// Interquartile range of a marked set of signed samples. A four-beat input
// queue takes samples while the sorter works. Each sample is insertion-sorted
// into a single-port-read RAM, compared against the stored entries from the top
// down, and every compare waits on a registered RAM read. A sample that arrives
// at capacity is dropped. After its own insert, the marked last sample makes 2
// or 4 quartile reads, each through the QRD and QACC states, and the result
// beat is then loaded into the output register once that register is free or
// being popped. That register holds the beat until it is popped. Sets of fewer
// than two samples or past capacity skip the quartile reads and report
// set_error with a zero spread.
module interquartile_range_core #(
    parameter int MAX_SAMPLES = iqr_pkg::IQR_MAX_SAMPLES,
    parameter int SAMPLE_BITS = iqr_pkg::IQR_SAMPLE_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  iqr_pkg::t_iqr_in  i_in_data,
    output logic              empty,
    input  logic              pop,
    output iqr_pkg::t_iqr_out o_out_data
);
    iqr_pkg::t_iqr_item w_item;
    iqr_pkg::t_iqr_link w_link;
    logic w_valid;

    iqr_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_in_data(i_in_data),
        .o_item   (w_item),
        .i_link   (w_link),
        .o_valid  (w_valid)
    );

    iqr_back #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (w_item),
        .i_valid   (w_valid),
        .o_link    (w_link),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_out_data(o_out_data)
    );
endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import iqr_pkg::*;

    localparam int CAP       = IQR_MAX_SAMPLES;
    localparam int END_WAIT  = 4000;
    localparam longint LIMIT = 64'd20000000;

    logic     i_clk;
    logic     i_rst_n;
    logic     push;
    logic     full;
    t_iqr_in  i_in_data;
    logic     empty;
    logic     pop;
    t_iqr_out o_out_data;

    interquartile_range_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_data  (i_in_data),
        .empty      (empty),
        .pop        (pop),
        .o_out_data (o_out_data)
    );

    t_iqr_in  pending_samples[$];
    t_iqr_out spread_expected[$];

    int        sorted_vals[CAP];
    int        held_n;
    bit        overflowed;
    int        failures;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        hold_cycles;
    bit        hold_armed;
    bit        stim_done;
    longint    cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // insertion sort of accepted samples, and quartile spread on the marked one
    function automatic void predict_sample(t_iqr_in beat);
        t_iqr_out r;
        int v, pos, h, k;
        longint diff;
        v = int'(beat.sample);
        if (held_n < CAP) begin
            pos = held_n;
            while (pos > 0 && sorted_vals[pos-1] > v) begin
                sorted_vals[pos] = sorted_vals[pos-1];
                pos--;
            end
            sorted_vals[pos] = v;
            held_n++;
        end else begin
            overflowed = 1'b1;
        end
        if (!beat.last_sample) return;
        r = '0;
        r.set_error = overflowed || held_n < 2;
        if (!r.set_error) begin
            h = held_n / 2;
            k = h / 2;
            if (h % 2 == 1)
                diff = 2 * (longint'(sorted_vals[held_n-1-k]) - sorted_vals[k]);
            else
                diff = longint'(sorted_vals[held_n-k]) + sorted_vals[held_n-1-k]
                     - sorted_vals[k] - sorted_vals[k-1];
            if (diff < 0) diff = 0;
            if (diff > SPREAD_MAX) diff = SPREAD_MAX;
            r.quartile_spread = diff[SPREAD_BITS-1:0];
        end
        spread_expected = {spread_expected, r};
        held_n = 0;
        overflowed = 1'b0;
    endfunction

    function automatic logic signed [15:0] rand_sample(int mode);
        case (mode)
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($urandom_range(0, 15)) - 16'sd8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_set(int len, int mode);
        t_iqr_in b;
        for (int i = 0; i < len; i++) begin
            b.sample = (mode == 4) ? rand_sample($urandom_range(0, 3)) : rand_sample(mode);
            b.last_sample = (i == len - 1);
            pending_samples = {pending_samples, b};
        end
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || spread_expected.size() != 0)
            @(posedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            i_in_data <= '0;
        end else begin
            if (push && !full) begin
                predict_sample(i_in_data);
                void'(pending_samples.pop_front());
            end
            if (pending_samples.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                push <= 1'b1;
                i_in_data <= pending_samples[0];
            end else begin
                push <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (spread_expected.size() == 0) begin
                    $display("%0t unexpected beat: actual %p", $time, o_out_data);
                    failures++;
                end else begin
                    if (o_out_data.quartile_spread !== spread_expected[0].quartile_spread
                        || o_out_data.set_error !== spread_expected[0].set_error) begin
                        $display("%0t mismatch: expected %p actual %p", $time,
                                 spread_expected[0], o_out_data);
                        failures++;
                    end
                    void'(spread_expected.pop_front());
                end
            end
            if (hold_armed) begin
                hold_armed <= 1'b0;
                hold_cycles <= 600;
                pop <= 1'b0;
            end else if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        t_iqr_in b;
        failures = 0;
        held_n = 0;
        overflowed = 1'b0;
        hold_cycles = 0;
        hold_armed = 1'b0;
        stim_done = 1'b0;
        cycle_count = 0;
        send_idle_pct = 31;
        recv_idle_pct = 81;
        push = 1'b0;
        pop = 1'b0;
        i_in_data = '0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed sets: tiny, extremes, all hinge parities
        queue_set(1, 3);
        queue_set(2, 0);
        queue_set(2, 1);
        queue_set(3, 4);
        queue_set(4, 4);
        queue_set(5, 2);
        queue_set(6, 4);
        queue_set(8, 0);
        b.sample = 16'sh8000; b.last_sample = 1'b0; pending_samples = {pending_samples, b};
        b.sample = 16'sh7fff; b.last_sample = 1'b1; pending_samples = {pending_samples, b};
        wait_drained();

        send_idle_pct = 31;
        recv_idle_pct = 81;
        queue_set(CAP, 4);
        queue_set(CAP + 3, 3);
        for (int i = 0; i < 60; i++) queue_set($urandom_range(1, 12), 4);
        wait_drained();

        send_idle_pct = 81;
        recv_idle_pct = 31;
        for (int i = 0; i < 60; i++) queue_set($urandom_range(1, 12), 4);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_armed = 1'b1;
        for (int i = 0; i < 100; i++) queue_set($urandom_range(1, 14), 4);
        wait_drained();

        repeat (END_WAIT) @(posedge i_clk);
        if (failures == 0 && spread_expected.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/iqr_pkg.sv
hdl/iqr_ram.sv
hdl/iqr_front.sv
hdl/iqr_back.sv
hdl/interquartile_range_core.sv
verif/tb_top.sv
